FILE: hw/rtl/bfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_pkg
// Types, codes and sizes used by the shortest-path engine.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int VERT_W         = 5;
    localparam int CNT_W          = 6;
    localparam int DEF_VERTICES   = 32;
    localparam int DEF_EDGES      = 256;
    localparam int PATH_LIMIT_MAX = 32;
    localparam logic [CNT_W-1:0] VCOUNT_RESET = 6'd32;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_PATH    = 2'd0;
    localparam logic [1:0] ST_NO_PATH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [VERT_W-1:0] src_vertex;
        logic [VERT_W-1:0] dst_vertex;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [VERT_W-1:0] path_vertex;
        logic [VERT_W-1:0] hop_count;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_NEXT_VTX,
        S_WALK,
        S_EMIT
    } state_t;

endpackage

FILE: hw/rtl/bfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfs_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/bfs_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_shortest_path
// Directed edge store with a breadth-first shortest-path search engine.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item) carries add-edge, query and
// clear items. Output channel (out_valid / out_stall / out_item) returns
// results; the last result of an item has last set. cfg_we / cfg_wdata
// write the vertex count; the user must do so only while idle, as the
// block does not enforce it. An add with a bad vertex or a full
// table gives one error result. A query clears the per-vertex marks,
// then scans the edge table once per dequeued vertex, each edge taking a
// RAM read, then a compare, then walks predecessors one path vertex per
// cycle and emits the path one result per cycle while not stalled.
// in_stall is high while a query runs and while a result waits under stall.
// A stalled result is held in the output register until taken.
// Reset empties the edge table, clears the seen and predecessor marks and
// sets the vertex count to 32. No clearing pass is needed.
// ----------------------------------------------------------------------------
module bfs_shortest_path #(
    parameter int MAX_VERTICES = bfs_pkg::DEF_VERTICES,
    parameter int MAX_EDGES    = bfs_pkg::DEF_EDGES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  bfs_pkg::in_item_t        in_item,
    output logic                     out_valid,
    input  logic                     out_stall,
    output bfs_pkg::out_item_t       out_item,
    input  logic                     cfg_we,
    input  logic [bfs_pkg::CNT_W-1:0] cfg_wdata
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int QPW   = $clog2(MAX_VERTICES + 1);
    localparam int EA    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW   = $clog2(MAX_EDGES + 1);
    localparam int LIMIT = (MAX_VERTICES < bfs_pkg::PATH_LIMIT_MAX) ?
                           MAX_VERTICES : bfs_pkg::PATH_LIMIT_MAX;
    localparam int SW    = $clog2(LIMIT);
    localparam int DW    = $clog2(LIMIT + 1);
    localparam int NW    = $clog2(MAX_VERTICES + 1) + 1;
    localparam int XW    = 2 * bfs_pkg::VERT_W;

    bfs_pkg::state_t state_reg, state_next;

    logic [bfs_pkg::CNT_W-1:0] vcount_reg;
    logic [ECW-1:0]            edges_reg;
    logic [ECW-1:0]            eidx_reg;
    logic [QPW-1:0]            head_reg, tail_reg;
    logic [MAX_VERTICES-1:0]   seen_reg, pred_ok_reg;
    logic [bfs_pkg::VERT_W-1:0] pred_reg  [MAX_VERTICES];
    logic [bfs_pkg::VERT_W-1:0] queue_reg [MAX_VERTICES];
    logic [bfs_pkg::VERT_W-1:0] stack_reg [LIMIT];
    logic [DW-1:0]             depth_reg;
    logic [bfs_pkg::VERT_W-1:0] walk_reg, src_reg, dst_reg, hop_reg;
    logic                      out_valid_reg;
    bfs_pkg::out_item_t        out_item_reg;

    logic [NW-1:0]             n_active;
    logic                      accept, out_free, in_bad, out_load;
    logic                      ram_re;
    logic [XW-1:0]             ram_rdata;
    logic [bfs_pkg::VERT_W-1:0] e_src, e_tgt, u_vtx;
    logic                      e_match, e_enq, e_found, scan_done, more_vtx, walk_more;

    // clamp the register to 1..MAX_VERTICES
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_active = NW'(1);
        end
        else if (NW'(vcount_reg) > NW'(MAX_VERTICES))
        begin
            n_active = NW'(MAX_VERTICES);
        end
        else
        begin
            n_active = NW'(vcount_reg);
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != bfs_pkg::S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign in_bad   = (NW'(in_item.src_vertex) >= n_active) ||
                      (NW'(in_item.dst_vertex) >= n_active);

    // load a new result into the output register
    assign out_load = (accept &&
                       (((in_item.req_type == bfs_pkg::REQ_ADD) &&
                         (in_bad || edges_reg >= ECW'(MAX_EDGES))) ||
                        ((in_item.req_type == bfs_pkg::REQ_QUERY) && in_bad))) ||
                      ((state_reg == bfs_pkg::S_NEXT_VTX) && !more_vtx) ||
                      ((state_reg == bfs_pkg::S_EMIT) && out_free);

    assign ram_re    = (state_reg == bfs_pkg::S_SCAN_RD) && !scan_done;
    assign scan_done = (eidx_reg == edges_reg);
    assign e_src     = ram_rdata[XW-1:bfs_pkg::VERT_W];
    assign e_tgt     = ram_rdata[bfs_pkg::VERT_W-1:0];
    assign u_vtx     = queue_reg[head_reg[QPW-1:0] >= QPW'(MAX_VERTICES) ? '0 :
                                 VW'(head_reg)];
    // shared compare unit of the edge scan
    assign e_match   = (e_src == u_vtx) && (NW'(e_tgt) < n_active);
    assign e_enq     = e_match && !seen_reg[VW'(e_tgt)] && (tail_reg < QPW'(MAX_VERTICES));
    assign e_found   = e_match && (e_tgt == dst_reg);
    assign more_vtx  = (head_reg + QPW'(1) < tail_reg) &&
                       (head_reg + QPW'(1) < QPW'(MAX_VERTICES));
    assign walk_more = pred_ok_reg[VW'(walk_reg)] && (depth_reg < DW'(LIMIT));

    bfs_ram #(
        .WIDTH (XW),
        .DEPTH (MAX_EDGES),
        .AW    (EA)
    ) u_edges (
        .clk   (clk),
        .we    (accept && in_item.req_type == bfs_pkg::REQ_ADD && !in_bad &&
                edges_reg < ECW'(MAX_EDGES)),
        .waddr (edges_reg[EA-1:0]),
        .wdata ({in_item.src_vertex, in_item.dst_vertex}),
        .re    (ram_re),
        .raddr (eidx_reg[EA-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfs_pkg::S_IDLE:
            begin
                if (accept && in_item.req_type == bfs_pkg::REQ_QUERY && !in_bad)
                begin
                    state_next = (in_item.src_vertex == in_item.dst_vertex) ?
                                 bfs_pkg::S_WALK : bfs_pkg::S_SCAN_RD;
                end
            end
            bfs_pkg::S_SCAN_RD:
            begin
                state_next = scan_done ? bfs_pkg::S_NEXT_VTX : bfs_pkg::S_SCAN_EV;
            end
            bfs_pkg::S_SCAN_EV:
            begin
                state_next = e_found ? bfs_pkg::S_WALK : bfs_pkg::S_SCAN_RD;
            end
            bfs_pkg::S_NEXT_VTX:
            begin
                state_next = more_vtx ? bfs_pkg::S_SCAN_RD : bfs_pkg::S_IDLE;
            end
            bfs_pkg::S_WALK:
            begin
                if (!walk_more)
                begin
                    state_next = bfs_pkg::S_EMIT;
                end
            end
            bfs_pkg::S_EMIT:
            begin
                if (out_free && depth_reg == DW'(1))
                begin
                    state_next = bfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfs_pkg::S_IDLE;
            vcount_reg    <= bfs_pkg::VCOUNT_RESET;
            edges_reg     <= '0;
            eidx_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            seen_reg      <= '0;
            pred_ok_reg   <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                bfs_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_item.req_type)
                            bfs_pkg::REQ_ADD:
                            begin
                                if (!in_bad && edges_reg < ECW'(MAX_EDGES))
                                begin
                                    edges_reg <= edges_reg + ECW'(1);
                                end
                            end
                            bfs_pkg::REQ_QUERY:
                            begin
                                if (!in_bad)
                                begin
                                    seen_reg    <= MAX_VERTICES'(1) << VW'(in_item.src_vertex);
                                    pred_ok_reg <= '0;
                                    head_reg    <= '0;
                                    tail_reg    <= QPW'(1);
                                    eidx_reg    <= '0;
                                    depth_reg   <= DW'(1);
                                end
                            end
                            bfs_pkg::REQ_CLEAR:
                            begin
                                edges_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                bfs_pkg::S_SCAN_EV:
                begin
                    eidx_reg <= eidx_reg + ECW'(1);
                    if (e_enq)
                    begin
                        tail_reg                  <= tail_reg + QPW'(1);
                        seen_reg[VW'(e_tgt)]    <= 1'b1;
                        pred_ok_reg[VW'(e_tgt)] <= 1'b1;
                    end
                end
                bfs_pkg::S_NEXT_VTX:
                begin
                    head_reg <= head_reg + QPW'(1);
                    eidx_reg <= '0;
                end
                bfs_pkg::S_WALK:
                begin
                    if (walk_more)
                    begin
                        depth_reg <= depth_reg + DW'(1);
                    end
                end
                bfs_pkg::S_EMIT:
                begin
                    if (out_free)
                    begin
                        depth_reg <= depth_reg - DW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bfs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    src_reg      <= in_item.src_vertex;
                    dst_reg      <= in_item.dst_vertex;
                    walk_reg     <= in_item.dst_vertex;
                    queue_reg[0] <= in_item.src_vertex;
                    stack_reg[0] <= in_item.dst_vertex;
                    out_item_reg <= '{status: in_bad ? bfs_pkg::ST_RANGE : bfs_pkg::ST_FULL,
                                      path_vertex: '0, hop_count: '0, last: 1'b1};
                end
            end
            bfs_pkg::S_SCAN_EV:
            begin
                if (e_enq)
                begin
                    queue_reg[VW'(tail_reg)] <= e_tgt;
                    pred_reg[VW'(e_tgt)]     <= u_vtx;
                end
            end
            bfs_pkg::S_NEXT_VTX:
            begin
                out_item_reg <= '{status: bfs_pkg::ST_NO_PATH, path_vertex: '0,
                                  hop_count: '0, last: 1'b1};
            end
            bfs_pkg::S_WALK:
            begin
                if (walk_more)
                begin
                    stack_reg[SW'(depth_reg)] <= pred_reg[VW'(walk_reg)];
                    walk_reg                  <= pred_reg[VW'(walk_reg)];
                end
                else
                begin
                    hop_reg <= bfs_pkg::VERT_W'(depth_reg - DW'(1));
                end
            end
            bfs_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_item_reg <= '{status: bfs_pkg::ST_PATH,
                                      path_vertex: stack_reg[SW'(depth_reg - DW'(1))],
                                      hop_count: hop_reg,
                                      last: depth_reg == DW'(1)};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == bfs_pkg::S_IDLE)
        else $error("input taken outside idle");
    a_tail_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= QPW'(MAX_VERTICES) && head_reg <= tail_reg)
        else $error("visit queue pointers out of range");
    a_emit_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfs_pkg::S_EMIT |-> depth_reg != '0)
        else $error("emit with empty path stack");
    a_scan_src: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfs_pkg::S_SCAN_EV |-> seen_reg[VW'(src_reg)])
        else $error("source not marked during scan");
`endif

endmodule
